// ===== sv/cst_pkg.sv =====
// ----------------------------------------------------------------------------
// Counting semaphore table package
// Operation and status codes and the command kind shared by the front and the
// back of the semaphore table.
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam int ID_W     = 7;
  localparam int STATUS_W = 3;
  localparam int MODE_W   = 2;

  localparam logic [MODE_W-1:0] MODE_CREATE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WAIT   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SIGNAL = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_ID    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_EXIST = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_FREE   = 3'd4;

  typedef enum logic [2:0] {
    K_CREATE,
    K_WAIT,
    K_SIGNAL,
    K_DELETE,
    K_BAD
  } cst_kind_e;

  localparam int KIND_W = 3;

endpackage

// ===== sv/counting_semaphore_table.sv =====
// ----------------------------------------------------------------------------
// Counting semaphore table
// A table of counting semaphores with create, wait, signal and delete.
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel: tuser carries the operation and
// tdata the one-based id and the initial and maximum counts. Every request
// produces exactly one word on the m_axis channel with a status code and,
// for a successful create, the new id.
// A request is classified on acceptance and queued in a two-word queue. The
// back end takes one command at a time: in its idle state it pops the
// command and reads the count and limit memory; in its execute state, once
// the output register is free, it applies the update and loads the output
// register. The back end pops no new command until the current one has
// executed, as the registered count memory read comes ahead of its update.
// Reset clears all active marks; counts and limits are written by create.
// While the receiver stalls, the result is held in the output register, the
// queue keeps accepting until full, and then s_axis_tready drops.
// ----------------------------------------------------------------------------
module counting_semaphore_table #(
  parameter int ENTRIES    = 64,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,   // mode
  input  logic [39:0] s_axis_tdata,   // sem_id, initial_count, max_count
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // status, new_id
);
  import cst_pkg::*;

  localparam int IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int QW   = KIND_W + IdxW + 2 * COUNT_BITS;

  logic                  push;
  logic                  full;
  logic                  pop;
  logic                  q_valid;
  cst_kind_e             f_kind;
  logic [IdxW-1:0]       f_idx;
  logic [COUNT_BITS-1:0] f_init;
  logic [COUNT_BITS-1:0] f_lim;
  logic [QW-1:0]         q_wdata;
  logic [QW-1:0]         q_rdata;

  cst_front #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS),
    .IDX_W      (IdxW)
  ) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .full_i        (full),
    .push_o        (push),
    .kind_o        (f_kind),
    .idx_o         (f_idx),
    .init_o        (f_init),
    .lim_o         (f_lim)
  );

  assign q_wdata = {f_lim, f_init, f_idx, f_kind};

  cst_fifo #(
    .WIDTH (QW),
    .DEPTH (2)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (q_wdata),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  cst_back #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS),
    .IDX_W      (IdxW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_kind_i      (cst_kind_e'(q_rdata[KIND_W-1:0])),
    .q_idx_i       (q_rdata[KIND_W+IdxW-1:KIND_W]),
    .q_init_i      (q_rdata[KIND_W+IdxW+COUNT_BITS-1:KIND_W+IdxW]),
    .q_lim_i       (q_rdata[QW-1:KIND_W+IdxW+COUNT_BITS]),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ===== sv/cst_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module cst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/cst_fifo.sv =====
// ----------------------------------------------------------------------------
// Command queue
// Short first-in first-out queue that decouples the classifier from the
// executing back end.
// ----------------------------------------------------------------------------
module cst_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign rdata_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= wdata_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("command queue holds more words than its depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("command queue popped while empty");

endmodule

// ===== sv/cst_front.sv =====
// ----------------------------------------------------------------------------
// Semaphore table front end
// Accepts request words, checks the id range and turns each word into a
// command for the back end.
// ----------------------------------------------------------------------------
module cst_front #(
  parameter int ENTRIES    = 64,
  parameter int COUNT_BITS = 16,
  parameter int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [1:0]            s_axis_tuser,   // mode
  input  logic [39:0]           s_axis_tdata,   // sem_id, initial_count, max_count
  input  logic                  full_i,
  output logic                  push_o,
  output cst_pkg::cst_kind_e    kind_o,
  output logic [IDX_W-1:0]      idx_o,
  output logic [COUNT_BITS-1:0] init_o,
  output logic [COUNT_BITS-1:0] lim_o
);
  import cst_pkg::*;

  logic [ID_W-1:0] sem_id;
  logic [15:0]     initial_count;
  logic [15:0]     max_count;
  logic            in_range;

  assign sem_id        = s_axis_tdata[6:0];
  assign initial_count = s_axis_tdata[22:7];
  assign max_count     = s_axis_tdata[38:23];

  assign s_axis_tready = !full_i;
  assign push_o        = s_axis_tvalid && !full_i;

  assign in_range = (sem_id != '0) && (sem_id <= ID_W'(ENTRIES));
  assign idx_o    = IDX_W'(sem_id - ID_W'(1));
  assign init_o   = COUNT_BITS'(initial_count);
  assign lim_o    = COUNT_BITS'(max_count);

  always_comb begin
    unique case (s_axis_tuser)
      MODE_CREATE: kind_o = K_CREATE;
      MODE_WAIT:   kind_o = in_range ? K_WAIT : K_BAD;
      MODE_SIGNAL: kind_o = in_range ? K_SIGNAL : K_BAD;
      MODE_DELETE: kind_o = in_range ? K_DELETE : K_BAD;
      default:     kind_o = K_BAD;
    endcase
  end

endmodule

// ===== sv/cst_back.sv =====
// ----------------------------------------------------------------------------
// Semaphore table back end
// Holds the active marks and the count and limit memory, executes one
// command at a time and registers its result word.
// ----------------------------------------------------------------------------
module cst_back #(
  parameter int ENTRIES    = 64,
  parameter int COUNT_BITS = 16,
  parameter int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  cst_pkg::cst_kind_e    q_kind_i,
  input  logic [IDX_W-1:0]      q_idx_i,
  input  logic [COUNT_BITS-1:0] q_init_i,
  input  logic [COUNT_BITS-1:0] q_lim_i,
  output logic                  pop_o,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [15:0]           m_axis_tdata    // status, new_id
);
  import cst_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;
  localparam int   RamW   = 2 * COUNT_BITS;

  logic                  state_q, state_d;
  cst_kind_e             op_kind_q;
  logic [IDX_W-1:0]      op_idx_q;
  logic [COUNT_BITS-1:0] op_init_q;
  logic [COUNT_BITS-1:0] op_lim_q;

  logic [ENTRIES-1:0]    marks_q, marks_d;
  logic [IDX_W-1:0]      free_idx_q, free_idx_d;
  logic                  free_any_q, free_any_d;

  logic                  out_valid_q;
  logic [STATUS_W-1:0]   status_q, status_d;
  logic [ID_W-1:0]       new_id_q, new_id_d;

  logic                  exec_go;
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [RamW-1:0]       ram_wdata;
  logic [RamW-1:0]       ram_rdata;
  logic [COUNT_BITS-1:0] cnt;
  logic [COUNT_BITS-1:0] lmt;

  assign pop_o   = (state_q == S_IDLE) && q_valid_i;
  assign exec_go = (state_q == S_EXEC) && (!out_valid_q || m_axis_tready);
  assign cnt     = ram_rdata[COUNT_BITS-1:0];
  assign lmt     = ram_rdata[RamW-1:COUNT_BITS];

  cst_ram #(
    .WIDTH  (RamW),
    .DEPTH  (ENTRIES),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (pop_o),
    .raddr_i (q_idx_i),
    .rdata_o (ram_rdata)
  );

  // The lowest free entry is kept registered and follows the marks in the cycle after.
  always_comb begin
    free_idx_d = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!marks_q[i]) begin
        free_idx_d = IDX_W'(i);
      end
    end
    free_any_d = !(&marks_q);
  end

  always_comb begin
    state_d   = state_q;
    marks_d   = marks_q;
    status_d  = ST_OK;
    new_id_d  = '0;
    ram_we    = 1'b0;
    ram_waddr = op_idx_q;
    ram_wdata = {lmt, cnt};
    if (pop_o) begin
      state_d = S_EXEC;
    end
    if (exec_go) begin
      state_d = S_IDLE;
      case (op_kind_q)
        K_CREATE: begin
          if (free_any_q) begin
            marks_d[free_idx_q] = 1'b1;
            new_id_d  = ID_W'(free_idx_q) + ID_W'(1);
            ram_we    = 1'b1;
            ram_waddr = free_idx_q;
            ram_wdata = {op_lim_q, op_init_q};
          end else begin
            status_d = ST_NO_FREE;
          end
        end
        K_DELETE: begin
          marks_d[op_idx_q] = 1'b0;
        end
        K_WAIT: begin
          if (!marks_q[op_idx_q]) begin
            status_d = ST_NOT_EXIST;
          end else if (cnt != '0) begin
            ram_we    = 1'b1;
            ram_wdata = {lmt, cnt - COUNT_BITS'(1)};
          end else begin
            status_d = ST_TIMEOUT;
          end
        end
        K_SIGNAL: begin
          if (!marks_q[op_idx_q]) begin
            status_d = ST_NOT_EXIST;
          end else if (cnt < lmt) begin
            ram_we    = 1'b1;
            ram_wdata = {lmt, cnt + COUNT_BITS'(1)};
          end
        end
        default: begin
          status_d = ST_BAD_ID;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      marks_q     <= '0;
      free_idx_q  <= '0;
      free_any_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      marks_q    <= marks_d;
      free_idx_q <= free_idx_d;
      free_any_q <= free_any_d;
      if (exec_go) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      op_kind_q <= q_kind_i;
      op_idx_q  <= q_idx_i;
      op_init_q <= q_init_i;
      op_lim_q  <= q_lim_i;
    end
    if (exec_go) begin
      status_q <= status_d;
      new_id_q <= new_id_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, new_id_q, status_q};

  a_free_tracks_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (free_any_q == !(&$past(marks_q))))
    else $error("free entry flag out of step with the active marks");

  a_create_sets_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_go && op_kind_q == K_CREATE && free_any_q) |=> marks_q[$past(free_idx_q)])
    else $error("successful create left its entry inactive");

  a_id_only_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((new_id_q == '0) || (status_q == ST_OK)))
    else $error("nonzero id reported with an error status");

  a_write_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_EXEC))
    else $error("count memory written outside execution");

endmodule
